FILE: rtl/sparse_polynomial_add_merge_core_defines.svh
// Assertion macros for the sparse polynomial merge core.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_CORE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPADD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SPADD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPADD_ASSERT_SAME(lbl, ante, cons, msg)
`define SPADD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/spadd_pkg.sv
`default_nettype none
package spadd_pkg;

	localparam int EXP_W      = 16;
	localparam int COEF_W     = 32;
	localparam int SUM_W      = 33;
	localparam int S_DATA_W   = 48;
	localparam int S_USER_W   = 2;
	localparam int M_DATA_W   = 56;
	localparam int M_USER_W   = 2;
	localparam int M_PAD_W    = M_DATA_W - SUM_W - EXP_W;

	typedef enum logic [S_USER_W-1:0] {
		REQ_LOAD_FIRST  = 2'd0,
		REQ_LOAD_SECOND = 2'd1,
		REQ_MERGE       = 2'd2
	} req_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic        [EXP_W-1:0]  exponent;
	} term_t;

	typedef struct packed {
		logic load_first;
		logic load_second;
		logic start;
		logic fire;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_next;
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/spadd_ctrl.sv
`default_nettype none
module spadd_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	input  wire logic [spadd_pkg::S_USER_W-1:0]   s_axis_tuser,
	output logic                                  s_axis_tready,
	input  wire spadd_pkg::status_t               st,
	output spadd_pkg::cmd_t                       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECIDE
	} state_t;

	state_t            state_q;
	logic              tready_q;
	logic              accept;
	spadd_pkg::req_t   req;

	assign s_axis_tready = tready_q;
	assign accept        = s_axis_tvalid && tready_q;
	assign req           = spadd_pkg::req_t'(s_axis_tuser);

	always_comb begin
		cmd             = '0;
		cmd.load_first  = accept && (req == spadd_pkg::REQ_LOAD_FIRST);
		cmd.load_second = accept && (req == spadd_pkg::REQ_LOAD_SECOND);
		cmd.start       = accept && (req == spadd_pkg::REQ_MERGE);
		cmd.fire        = (state_q == ST_DECIDE) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q  <= ST_FETCH;
						tready_q <= 1'b0;
					end
				end
				ST_FETCH: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (cmd.fire) begin
						if (st.last_next) begin
							state_q  <= ST_IDLE;
							tready_q <= 1'b1;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q  <= ST_IDLE;
					tready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/spadd_datapath.sv
`default_nettype none
`include "sparse_polynomial_add_merge_core_defines.svh"
module spadd_datapath #(
	parameter int MAX_TERMS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire spadd_pkg::cmd_t                     cmd,
	output spadd_pkg::status_t                       st,
	input  wire spadd_pkg::term_t                    load_term,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic        [spadd_pkg::EXP_W-1:0]       out_exponent,
	output logic signed [spadd_pkg::SUM_W-1:0]       out_coefficient,
	output logic                                     out_last,
	output logic                                     out_empty,
	output logic                                     out_dropped
);

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);

	spadd_pkg::term_t mem_a [MAX_TERMS];
	spadd_pkg::term_t mem_b [MAX_TERMS];

	spadd_pkg::term_t rd_a_q;
	spadd_pkg::term_t rd_b_q;

	logic [CNT_W-1:0] cnt_a_q;
	logic [CNT_W-1:0] cnt_b_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic             ovf_q;

	logic                                valid_q;
	logic        [spadd_pkg::EXP_W-1:0]  exp_q;
	logic signed [spadd_pkg::SUM_W-1:0]  coef_q;
	logic                                last_q;
	logic                                empty_q;
	logic                                dropped_q;

	logic                                a_left;
	logic                                b_left;
	logic                                sel_a;
	logic                                sel_b;
	logic                                a_room;
	logic                                b_room;
	logic signed [spadd_pkg::SUM_W-1:0]  add_a;
	logic signed [spadd_pkg::SUM_W-1:0]  add_b;
	logic signed [spadd_pkg::SUM_W-1:0]  sum;
	logic        [spadd_pkg::EXP_W-1:0]  exp_sel;
	logic        [CNT_W-1:0]             i_next;
	logic        [CNT_W-1:0]             j_next;

	assign a_room = cnt_a_q < CNT_W'(MAX_TERMS);
	assign b_room = cnt_b_q < CNT_W'(MAX_TERMS);
	assign a_left = i_q < cnt_a_q;
	assign b_left = j_q < cnt_b_q;

	assign sel_a = a_left && (!b_left || (rd_a_q.exponent >= rd_b_q.exponent));
	assign sel_b = b_left && (!a_left || (rd_b_q.exponent >= rd_a_q.exponent));

	assign add_a   = sel_a ? spadd_pkg::SUM_W'(rd_a_q.coefficient) : '0;
	assign add_b   = sel_b ? spadd_pkg::SUM_W'(rd_b_q.coefficient) : '0;
	assign sum     = add_a + add_b;
	assign exp_sel = sel_a ? rd_a_q.exponent : (sel_b ? rd_b_q.exponent : '0);

	assign i_next = i_q + CNT_W'(sel_a);
	assign j_next = j_q + CNT_W'(sel_b);

	always_comb begin
		st           = '0;
		st.out_free  = !valid_q || out_ready;
		st.last_next = (i_next >= cnt_a_q) && (j_next >= cnt_b_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_first && a_room) begin
			mem_a[cnt_a_q[IDX_W-1:0]] <= load_term;
		end
		if (cmd.load_second && b_room) begin
			mem_b[cnt_b_q[IDX_W-1:0]] <= load_term;
		end
		rd_a_q <= mem_a[i_q[IDX_W-1:0]];
		rd_b_q <= mem_b[j_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load_first) begin
				if (a_room) begin
					cnt_a_q <= cnt_a_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.load_second) begin
				if (b_room) begin
					cnt_b_q <= cnt_b_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				i_q <= '0;
				j_q <= '0;
			end
			if (cmd.fire) begin
				valid_q <= 1'b1;
				i_q     <= i_next;
				j_q     <= j_next;
				if (st.last_next) begin
					cnt_a_q <= '0;
					cnt_b_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			exp_q     <= exp_sel;
			coef_q    <= sum;
			empty_q   <= !a_left && !b_left;
			last_q    <= (a_left || b_left) && st.last_next;
			dropped_q <= (a_left || b_left) && ovf_q;
		end
	end

	assign out_valid       = valid_q;
	assign out_exponent    = exp_q;
	assign out_coefficient = coef_q;
	assign out_last        = last_q;
	assign out_empty       = empty_q;
	assign out_dropped     = dropped_q;

	`SPADD_ASSERT_SAME(a_fire_free, cmd.fire, !valid_q || out_ready, "result overwritten before transaction")
	`SPADD_ASSERT_NEXT(a_finish_clear, cmd.fire && st.last_next, (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q, "counts not cleared after merge")
	`SPADD_ASSERT_NEXT(a_empty_marks, cmd.fire && !a_left && !b_left, valid_q && empty_q && !last_q && (coef_q == '0), "empty result malformed")
	`SPADD_ASSERT_SAME(a_no_load_merge, cmd.fire, !cmd.load_first && !cmd.load_second, "load during merge")

endmodule
`default_nettype wire

FILE: rtl/sparse_polynomial_add_merge_core.sv
// Load transactions (first or second store) are taken one per cycle, also while a result waits.
// A merge transaction blocks intake; each result term is made by a store read, then a compare and
// emit into the output register once that register is free; an empty merge gives a single result.
// Reset clears both term counts, the drop flag and the output valid flag; store contents and
// the output data are not cleared, and store entries are only used below the counts.
`default_nettype none
module sparse_polynomial_add_merge_core #(
	parameter int MAX_TERMS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// term_exponent [15:0], term_coefficient [47:16]
	input  wire logic [spadd_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// req_type [1:0]
	input  wire logic [spadd_pkg::S_USER_W-1:0]    s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// sum_exponent [15:0], sum_coefficient [48:16], zero [55:49]
	output logic [spadd_pkg::M_DATA_W-1:0]         m_axis_tdata,
	// both_empty [0], terms_dropped [1]
	output logic [spadd_pkg::M_USER_W-1:0]         m_axis_tuser,
	output logic                                   m_axis_tlast
);

	spadd_pkg::cmd_t                              cmd;
	spadd_pkg::status_t                           st;
	spadd_pkg::term_t                             load_term;
	logic        [spadd_pkg::EXP_W-1:0]           out_exponent;
	logic signed [spadd_pkg::SUM_W-1:0]           out_coefficient;
	logic                                         out_empty;
	logic                                         out_dropped;

	assign load_term = spadd_pkg::term_t'(s_axis_tdata);

	spadd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	spadd_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.load_term       (load_term),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_exponent    (out_exponent),
		.out_coefficient (out_coefficient),
		.out_last        (m_axis_tlast),
		.out_empty       (out_empty),
		.out_dropped     (out_dropped)
	);

	assign m_axis_tdata = {{spadd_pkg::M_PAD_W{1'b0}}, out_coefficient, out_exponent};
	assign m_axis_tuser = {out_dropped, out_empty};

endmodule
`default_nettype wire
